// File: rtl/core/kwm_pkg.sv
// Shared types and constants for the k-way sorted merge core.
// Used by the controller, the datapath, the top level and the port checker.
// No dependencies.
`default_nettype none

package kwm_pkg;

   localparam int NUM_LISTS_DEFAULT  = 8;
   localparam int LIST_DEPTH_DEFAULT = 256;

   localparam int KIND_W   = 2;
   localparam int ID_W     = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 3;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_APPENDED = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_POPPED   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_CLEARED  = 3'd4;

   // controller to datapath
   typedef struct packed {
      logic latch_req;   // capture the request fields
      logic exec;        // run append / clear / drop, arm the minimum search
      logic scan_issue;  // read the head of the list under the scan index
      logic pop_commit;  // retire the chosen head, form the pop result
      logic load_out;    // move the pending result into the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              scan_last;
   } stat_type;

endpackage

`default_nettype wire

// File: rtl/core/k_way_sorted_merge_core.sv
// Top level of the k-way sorted merge core.
// Depends on kwm_pkg, kwm_ctrl and kwm_dpath.
//
// Usage:
//  - Request channel (req_valid/req_ready, req_kind, req_list_id,
//    req_elem_value): append a value to one list, pop the smallest head
//    over all lists (lowest list index wins a tie), or clear every list.
//    A kind of 3 and an append to a missing or full list are dropped.
//  - Response channel (rsp_valid/rsp_ready, rsp_out_value, rsp_out_list,
//    rsp_status): exactly one transfer per request, in request order.
//  - Items are handled one at a time by the controller. Append, clear and
//    dropped items pass through the execute and finish states before
//    response valid rises; the next request is taken back in idle.
//  - A pop passes through the execute, scan, drain, commit and finish states
//    before response valid rises and the next request is taken: the minimum
//    search reads one list head a cycle from the single-port list memory,
//    then the drain state empties the compare stage, commit retires the head.
//  - The result sits in an output register; a new request is taken while
//    it waits, and only the hand-over of the next result waits on
//    rsp_ready, so a stalled receiver holds the response steady and stops
//    the block after at most one further item.
//  - Reset empties every list at once; the list memory needs no clearing,
//    since only the heads of non-empty lists reach the compare stage.
`default_nettype none

module k_way_sorted_merge_core #(
   parameter int NUM_LISTS  = kwm_pkg::NUM_LISTS_DEFAULT,
   parameter int LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic        [kwm_pkg::KIND_W-1:0]    req_kind,
   input  wire logic        [kwm_pkg::ID_W-1:0]      req_list_id,
   input  wire logic signed [kwm_pkg::VALUE_W-1:0]   req_elem_value,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed      [kwm_pkg::VALUE_W-1:0]   rsp_out_value,
   output logic             [kwm_pkg::ID_W-1:0]      rsp_out_list,
   output logic             [kwm_pkg::STATUS_W-1:0]  rsp_status
);

   kwm_pkg::cmd_type  cmd;
   kwm_pkg::stat_type stat;

   // sequence each item: capture, execute, for a pop scan and retire, hand over
   kwm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // hold the lists and compute every result
   kwm_dpath #(
      .NUM_LISTS  (NUM_LISTS),
      .LIST_DEPTH (LIST_DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_kind       (req_kind),
      .req_list_id    (req_list_id),
      .req_elem_value (req_elem_value),
      .rsp_out_value  (rsp_out_value),
      .rsp_out_list   (rsp_out_list),
      .rsp_status     (rsp_status)
   );

endmodule

`default_nettype wire

// File: rtl/core/kwm_ctrl.sv
// Controller state machine for the k-way sorted merge core.
// Depends on kwm_pkg (command and status structs, item kinds).
`default_nettype none

module kwm_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire kwm_pkg::stat_type stat,
   output kwm_pkg::cmd_type       cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT,
      ST_FIN
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.latch_req  = (state_ff == ST_IDLE) && req_valid;
      cmd.exec       = (state_ff == ST_EXEC);
      cmd.scan_issue = (state_ff == ST_SCAN);
      cmd.pop_commit = (state_ff == ST_COMMIT);
      cmd.load_out   = (state_ff == ST_FIN) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop valid after the transfer unless the next result lands on the same edge
         if (rsp_valid_ff && rsp_ready && !cmd.load_out) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff     <= ST_EXEC;
                  req_ready_ff <= 1'b0;
               end
            end
            ST_EXEC: begin
               if (stat.kind == kwm_pkg::KIND_POP) begin
                  state_ff <= ST_SCAN;
               end else begin
                  state_ff <= ST_FIN;
               end
            end
            ST_SCAN: begin
               if (stat.scan_last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_COMMIT;
            end
            ST_COMMIT: begin
               state_ff <= ST_FIN;
            end
            ST_FIN: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  req_ready_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               req_ready_ff <= 1'b1;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/kwm_dpath.sv
// Datapath of the k-way sorted merge core: list memory, per-list pointers
// and counts, minimum search over the heads, result registers.
// Depends on kwm_pkg; driven by kwm_ctrl through cmd_type.
`default_nettype none

module kwm_dpath #(
   parameter int NUM_LISTS  = kwm_pkg::NUM_LISTS_DEFAULT,
   parameter int LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire kwm_pkg::cmd_type                     cmd,
   output kwm_pkg::stat_type                         stat,
   input  wire logic        [kwm_pkg::KIND_W-1:0]    req_kind,
   input  wire logic        [kwm_pkg::ID_W-1:0]      req_list_id,
   input  wire logic signed [kwm_pkg::VALUE_W-1:0]   req_elem_value,
   output logic signed      [kwm_pkg::VALUE_W-1:0]   rsp_out_value,
   output logic             [kwm_pkg::ID_W-1:0]      rsp_out_list,
   output logic             [kwm_pkg::STATUS_W-1:0]  rsp_status
);

   localparam int LIST_W   = $clog2(NUM_LISTS);
   localparam int PTR_W    = $clog2(LIST_DEPTH);
   localparam int CNT_W    = $clog2(LIST_DEPTH + 1);
   localparam int ADDR_W   = LIST_W + PTR_W;
   localparam int MEM_SIZE = 2 ** ADDR_W;
   localparam int VW       = kwm_pkg::VALUE_W;

   // captured request
   logic [kwm_pkg::KIND_W-1:0] kind_ff;
   logic [kwm_pkg::ID_W-1:0]   id_ff;
   logic [VW-1:0]              val_ff;

   // per-list state
   logic [PTR_W-1:0] head_ptr_ff [NUM_LISTS];
   logic [PTR_W-1:0] tail_ptr_ff [NUM_LISTS];
   logic [CNT_W-1:0] fill_ff     [NUM_LISTS];

   logic [VW-1:0] mem [MEM_SIZE];
   logic [VW-1:0] rd_data_ff;

   // minimum search
   logic [LIST_W-1:0] scan_idx_ff;
   logic              cmp_vld_ff;
   logic [LIST_W-1:0] cmp_idx_ff;
   logic              found_ff;
   logic [LIST_W-1:0] best_idx_ff;
   logic [VW-1:0]     best_val_ff;

   // pending result and output register
   logic [VW-1:0]                res_value_ff;
   logic [kwm_pkg::ID_W-1:0]     res_list_ff;
   logic [kwm_pkg::STATUS_W-1:0] res_status_ff;
   logic [VW-1:0]                out_value_ff;
   logic [kwm_pkg::ID_W-1:0]     out_list_ff;
   logic [kwm_pkg::STATUS_W-1:0] out_status_ff;

   logic [LIST_W-1:0] app_idx;
   logic              id_in_range;
   logic [LIST_W-1:0] sel_idx;
   logic [PTR_W-1:0]  sel_head;
   logic [PTR_W-1:0]  sel_tail;
   logic [CNT_W-1:0]  sel_fill;
   logic              is_append;
   logic              is_clear;
   logic              app_ok;
   logic              wr_en;
   logic [ADDR_W-1:0] mem_addr;
   logic              take_cmp;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(LIST_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   assign app_idx     = LIST_W'(id_ff);
   assign id_in_range = (32'(id_ff) < NUM_LISTS);

   // one index selects the per-list state for every phase
   always_comb begin
      if (cmd.scan_issue) begin
         sel_idx = scan_idx_ff;
      end else if (cmd.pop_commit) begin
         sel_idx = best_idx_ff;
      end else begin
         sel_idx = app_idx;
      end
   end

   assign sel_head  = head_ptr_ff[sel_idx];
   assign sel_tail  = tail_ptr_ff[sel_idx];
   assign sel_fill  = fill_ff[sel_idx];

   assign is_append = (kind_ff == kwm_pkg::KIND_APPEND);
   assign is_clear  = (kind_ff == kwm_pkg::KIND_CLEAR);
   assign app_ok    = id_in_range && (sel_fill != CNT_W'(LIST_DEPTH));
   assign wr_en     = cmd.exec && is_append && app_ok;
   assign mem_addr  = {sel_idx, (cmd.scan_issue ? sel_head : sel_tail)};
   assign take_cmp  = cmp_vld_ff &&
                      (!found_ff || ($signed(rd_data_ff) < $signed(best_val_ff)));

   assign stat.kind      = kind_ff;
   assign stat.scan_last = (scan_idx_ff == LIST_W'(NUM_LISTS - 1));

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         kind_ff <= req_kind;
         id_ff   <= req_list_id;
         val_ff  <= req_elem_value;
      end
   end

   // single-port list memory, read data registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[mem_addr] <= val_ff;
      end
      rd_data_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LISTS; i++) begin
            head_ptr_ff[i] <= '0;
            tail_ptr_ff[i] <= '0;
            fill_ff[i]     <= '0;
         end
      end else if (cmd.exec && is_clear) begin
         for (int i = 0; i < NUM_LISTS; i++) begin
            head_ptr_ff[i] <= '0;
            tail_ptr_ff[i] <= '0;
            fill_ff[i]     <= '0;
         end
      end else if (wr_en) begin
         tail_ptr_ff[sel_idx] <= ptr_next(sel_tail);
         fill_ff[sel_idx]     <= sel_fill + CNT_W'(1);
      end else if (cmd.pop_commit && found_ff) begin
         head_ptr_ff[sel_idx] <= ptr_next(sel_head);
         fill_ff[sel_idx]     <= sel_fill - CNT_W'(1);
      end
   end

   // scan issue stage and compare stage
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
         cmp_vld_ff  <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         cmp_vld_ff <= cmd.scan_issue && (sel_fill != '0);
         if (cmd.exec) begin
            scan_idx_ff <= '0;
         end else if (cmd.scan_issue) begin
            scan_idx_ff <= scan_idx_ff + LIST_W'(1);
         end
         if (cmd.exec) begin
            found_ff <= 1'b0;
         end else if (take_cmp) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_issue) begin
         cmp_idx_ff <= scan_idx_ff;
      end
      if (take_cmp) begin
         best_idx_ff <= cmp_idx_ff;
         best_val_ff <= rd_data_ff;
      end
   end

   // pending result
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         res_value_ff <= '0;
         res_list_ff  <= '0;
         case (kind_ff)
            kwm_pkg::KIND_APPEND: begin
               res_status_ff <= app_ok ? kwm_pkg::STATUS_APPENDED
                                       : kwm_pkg::STATUS_DROPPED;
            end
            kwm_pkg::KIND_CLEAR: begin
               res_status_ff <= kwm_pkg::STATUS_CLEARED;
            end
            default: begin
               res_status_ff <= kwm_pkg::STATUS_DROPPED;
            end
         endcase
      end else if (cmd.pop_commit) begin
         if (found_ff) begin
            res_value_ff  <= best_val_ff;
            res_list_ff   <= kwm_pkg::ID_W'(best_idx_ff);
            res_status_ff <= kwm_pkg::STATUS_POPPED;
         end else begin
            res_value_ff  <= '0;
            res_list_ff   <= '0;
            res_status_ff <= kwm_pkg::STATUS_EMPTY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_value_ff  <= res_value_ff;
         out_list_ff   <= res_list_ff;
         out_status_ff <= res_status_ff;
      end
   end

   assign rsp_out_value = $signed(out_value_ff);
   assign rsp_out_list  = out_list_ff;
   assign rsp_status    = out_status_ff;

endmodule

`default_nettype wire

// File: rtl/core/kwm_checker.sv
// Port-level checker for the k-way sorted merge core, bound to the top level.
// Depends on kwm_pkg (status codes and field widths).
`default_nettype none

module kwm_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_valid,
   input wire logic                                 req_ready,
   input wire logic        [kwm_pkg::KIND_W-1:0]    req_kind,
   input wire logic        [kwm_pkg::ID_W-1:0]      req_list_id,
   input wire logic signed [kwm_pkg::VALUE_W-1:0]   req_elem_value,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_ready,
   input wire logic signed [kwm_pkg::VALUE_W-1:0]   rsp_out_value,
   input wire logic        [kwm_pkg::ID_W-1:0]      rsp_out_list,
   input wire logic        [kwm_pkg::STATUS_W-1:0]  rsp_status
);

   logic unused_req;
   assign unused_req = ^{req_kind, req_list_id, req_elem_value};

   // a stalled response holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_value) &&
                                  $stable(rsp_out_list) && $stable(rsp_status))
      else $error("stalled response changed");

   // only a pop result carries a value and a list index
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != kwm_pkg::STATUS_POPPED) |->
         (rsp_out_value == '0) && (rsp_out_list == '0))
      else $error("non-pop response carries a value");

   // status is one of the defined codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == kwm_pkg::STATUS_APPENDED) ||
                    (rsp_status == kwm_pkg::STATUS_POPPED)   ||
                    (rsp_status == kwm_pkg::STATUS_DROPPED)  ||
                    (rsp_status == kwm_pkg::STATUS_EMPTY)    ||
                    (rsp_status == kwm_pkg::STATUS_CLEARED))
      else $error("undefined response status");

   // one item in flight: a request transfer closes the request side
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in flight");

endmodule

bind k_way_sorted_merge_core kwm_checker u_kwm_checker (.*);

`default_nettype wire

// File: tb/kwm_merge_checker.sv
`timescale 1ns / 1ps
// Response checker for the k-way sorted merge core: keeps its own copy of the
// lists, predicts each response from the request transfers and compares.
// Depends on kwm_pkg.
module kwm_merge_checker #(
   parameter int NUM_LISTS  = kwm_pkg::NUM_LISTS_DEFAULT,
   parameter int LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic        [kwm_pkg::KIND_W-1:0]   req_kind,
   input  logic        [kwm_pkg::ID_W-1:0]     req_list_id,
   input  logic signed [kwm_pkg::VALUE_W-1:0]  req_elem_value,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [kwm_pkg::VALUE_W-1:0]  rsp_out_value,
   input  logic        [kwm_pkg::ID_W-1:0]     rsp_out_list,
   input  logic        [kwm_pkg::STATUS_W-1:0] rsp_status,
   output int                                  outstanding,
   output int                                  mismatches
);

   typedef struct packed {
      logic signed [kwm_pkg::VALUE_W-1:0]  value;
      logic        [kwm_pkg::ID_W-1:0]     list;
      logic        [kwm_pkg::STATUS_W-1:0] status;
   } merge_result_type;

   logic signed [kwm_pkg::VALUE_W-1:0] list_mem [NUM_LISTS][LIST_DEPTH];
   int head_idx [NUM_LISTS];
   int tail_idx [NUM_LISTS];
   int fill     [NUM_LISTS];

   merge_result_type awaited_results [$];
   int requests_taken = 0;
   int responses_seen = 0;
   int mismatch_total = 0;

   assign outstanding = requests_taken - responses_seen;
   assign mismatches  = mismatch_total;

   function automatic void empty_lists();
      for (int i = 0; i < NUM_LISTS; i++) begin
         head_idx[i] = 0;
         tail_idx[i] = 0;
         fill[i]     = 0;
      end
   endfunction

   // advance the list state by one request and return the response it earns
   function automatic merge_result_type next_merge_result(
      input logic        [kwm_pkg::KIND_W-1:0]  kind,
      input logic        [kwm_pkg::ID_W-1:0]    id,
      input logic signed [kwm_pkg::VALUE_W-1:0] value
   );
      merge_result_type res;
      bit               found;
      int               best;
      res        = '0;
      res.status = kwm_pkg::STATUS_DROPPED;
      found      = 1'b0;
      best       = 0;
      case (kind)
         kwm_pkg::KIND_APPEND: begin
            if (int'(id) < NUM_LISTS && fill[id] < LIST_DEPTH) begin
               list_mem[id][tail_idx[id]] = value;
               tail_idx[id] = (tail_idx[id] + 1) % LIST_DEPTH;
               fill[id]++;
               res.status = kwm_pkg::STATUS_APPENDED;
            end
         end
         kwm_pkg::KIND_POP: begin
            // strict less-than keeps the lowest index on equal heads
            for (int i = 0; i < NUM_LISTS; i++) begin
               if (fill[i] != 0 &&
                   (!found || list_mem[i][head_idx[i]] < list_mem[best][head_idx[best]])) begin
                  found = 1'b1;
                  best  = i;
               end
            end
            if (found) begin
               res.value  = list_mem[best][head_idx[best]];
               res.list   = best[kwm_pkg::ID_W-1:0];
               res.status = kwm_pkg::STATUS_POPPED;
               head_idx[best] = (head_idx[best] + 1) % LIST_DEPTH;
               fill[best]--;
            end else begin
               res.status = kwm_pkg::STATUS_EMPTY;
            end
         end
         kwm_pkg::KIND_CLEAR: begin
            empty_lists();
            res.status = kwm_pkg::STATUS_CLEARED;
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      merge_result_type seen;
      merge_result_type wanted;
      merge_result_type predicted;
      if (reset) begin
         empty_lists();
         awaited_results.delete();
         requests_taken = 0;
         responses_seen = 0;
      end else begin
         if (req_valid && req_ready) begin
            predicted = next_merge_result(req_kind, req_list_id, req_elem_value);
            awaited_results.insert(awaited_results.size(), predicted);
            requests_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            seen.value  = rsp_out_value;
            seen.list   = rsp_out_list;
            seen.status = rsp_status;
            if (awaited_results.size() == 0) begin
               $display("%0t: response with none awaited: value %0d list %0d status %0d",
                        $time, seen.value, seen.list, seen.status);
               mismatch_total++;
            end else begin
               wanted = awaited_results.pop_front();
               responses_seen++;
               if (seen !== wanted) begin
                  $display({"%0t: response mismatch: expected value %0d list %0d",
                            " status %0d, got value %0d list %0d status %0d"},
                           $time, wanted.value, wanted.list, wanted.status,
                           seen.value, seen.list, seen.status);
                  mismatch_total++;
               end
            end
         end
      end
   end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the k-way sorted merge core: drives requests and the
// response back-pressure, runs a watchdog and prints the verdict.
// Depends on kwm_pkg, k_way_sorted_merge_core and kwm_merge_checker.
module tb_top;

   localparam int NUM_LISTS  = kwm_pkg::NUM_LISTS_DEFAULT;
   localparam int LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEFAULT;

   // kind 3 has no meaning in the block; it must be dropped
   localparam logic [kwm_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

   localparam int ITEM_TARGET    = 950;
   localparam int PHASE_ITEMS    = 80;
   localparam int WATCHDOG_LIMIT = 2000;
   // a pop is the slowest item; the drain time spans two of them
   localparam int DRAIN_CYCLES   = 2 * (NUM_LISTS + 5);

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_valid      = 1'b0;
   logic                                req_ready;
   logic        [kwm_pkg::KIND_W-1:0]   req_kind       = '0;
   logic        [kwm_pkg::ID_W-1:0]     req_list_id    = '0;
   logic signed [kwm_pkg::VALUE_W-1:0]  req_elem_value = '0;
   logic                                rsp_valid;
   logic                                rsp_ready      = 1'b0;
   logic signed [kwm_pkg::VALUE_W-1:0]  rsp_out_value;
   logic        [kwm_pkg::ID_W-1:0]     rsp_out_list;
   logic        [kwm_pkg::STATUS_W-1:0] rsp_status;

   int outstanding;
   int mismatches;

   int items_sent      = 0;
   int active_phase    = -1;
   int sender_idle_pct = 0;
   int recv_stall_pct  = 0;
   int quiet_cycles    = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   k_way_sorted_merge_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_list_id    (req_list_id),
      .req_elem_value (req_elem_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_value  (rsp_out_value),
      .rsp_out_list   (rsp_out_list),
      .rsp_status     (rsp_status)
   );

   kwm_merge_checker #(
      .NUM_LISTS  (NUM_LISTS),
      .LIST_DEPTH (LIST_DEPTH)
   ) merge_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_list_id    (req_list_id),
      .req_elem_value (req_elem_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_value  (rsp_out_value),
      .rsp_out_list   (rsp_out_list),
      .rsp_status     (rsp_status),
      .outstanding    (outstanding),
      .mismatches     (mismatches)
   );

   // Receiver back-pressure: redraw ready on every falling edge so that stalls
   // land on any cycle of the block's work, including mid-search.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Watchdog: count cycles without a transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Offer one request and hold it until the transfer. Every PHASE_ITEMS
   // requests the idling mix changes; before that, hold off until the block
   // has answered everything, so that it starts the new phase empty.
   task automatic send_item(
      input logic        [kwm_pkg::KIND_W-1:0]  kind,
      input logic        [kwm_pkg::ID_W-1:0]    id,
      input logic signed [kwm_pkg::VALUE_W-1:0] value
   );
      int phase;
      phase = (items_sent / PHASE_ITEMS) % 4;
      @(negedge clock);
      if (phase != active_phase) begin
         req_valid <= 1'b0;
         do @(negedge clock); while (outstanding != 0);
         active_phase = phase;
         case (phase)
            0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin sender_idle_pct = 57; recv_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  recv_stall_pct = 57; end
            default: begin sender_idle_pct = 36; recv_stall_pct = 36; end
         endcase
      end
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_list_id    <= id;
      req_elem_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // Append a non-decreasing run to one list; equal neighbours are allowed
   // so that ties between lists turn up. Saturate at the top of the range.
   task automatic append_ascending(
      input logic [kwm_pkg::ID_W-1:0] list,
      input int                       count,
      input longint                   start,
      input int                       max_step
   );
      longint level;
      level = start;
      repeat (count) begin
         send_item(kwm_pkg::KIND_APPEND, list, 32'(level));
         level = level + $urandom_range(0, max_step);
         if (level > 64'sd2147483647) level = 64'sd2147483647;
      end
   endtask

   // Pops carry random list and value fields, which the block must ignore.
   task automatic pop_burst(input int count);
      repeat (count) send_item(kwm_pkg::KIND_POP, 3'($urandom), $urandom);
   endtask

   initial begin
      int                        pick;
      bit                        fill_done;
      logic [kwm_pkg::ID_W-1:0]  fill_list;
      longint                    base;
      fill_done = 1'b0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: pop with every list empty, extremes of the value range,
      // a tie between two lists, an unused kind, clear and pop after clear.
      pop_burst(1);
      send_item(kwm_pkg::KIND_APPEND, 3'd0, 32'sh7FFF_FFFF);
      send_item(kwm_pkg::KIND_APPEND, 3'd7, 32'sh8000_0000);
      send_item(kwm_pkg::KIND_APPEND, 3'd3, 32'sd0);
      send_item(kwm_pkg::KIND_APPEND, 3'd3, 32'sd5);
      send_item(kwm_pkg::KIND_APPEND, 3'd6, 32'sd100);
      send_item(kwm_pkg::KIND_APPEND, 3'd2, 32'sd100);
      send_item(KIND_UNUSED, 3'd7, 32'hFFFF_FFFF);
      send_item(KIND_UNUSED, 3'd0, 32'h0000_0000);
      pop_burst(7);   // min, 0, 5, tie on 100 (list 2 first), then max, then empty
      send_item(kwm_pkg::KIND_APPEND, 3'd1, -32'sd1);
      send_item(kwm_pkg::KIND_APPEND, 3'd4, 32'sd1);
      send_item(kwm_pkg::KIND_APPEND, 3'd5, 32'sh5555_AAAA);
      send_item(kwm_pkg::KIND_CLEAR, 3'd7, 32'hFFFF_FFFF);
      pop_burst(1);
      send_item(kwm_pkg::KIND_APPEND, 3'd4, -32'sd1);
      pop_burst(1);

      // Random: mostly sorted runs and pop bursts, with some clears, stray
      // kinds and unsorted appends mixed in.
      while (items_sent < ITEM_TARGET) begin
         if (!fill_done && items_sent >= 250) begin
            // Fill one list to the brim and past it, drain part, refill so
            // the tail wraps and it is full again, then drain it fully so
            // the head wraps and the final pops find nothing.
            fill_done = 1'b1;
            fill_list = 3'($urandom);
            send_item(kwm_pkg::KIND_CLEAR, 3'($urandom), $urandom);
            append_ascending(fill_list, LIST_DEPTH + 2,
                             longint'($urandom_range(0, 1000)) - 100000, 50);
            pop_burst(40);
            append_ascending(fill_list, 41, 64'sd1000000, 50);
            pop_burst(LIST_DEPTH + 2);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               if ($urandom_range(0, 1) == 0) base = longint'($signed($urandom));
               else base = longint'($urandom_range(0, 4000)) - 2000;
               append_ascending(3'($urandom), $urandom_range(1, 12), base, 300);
            end else if (pick < 80) begin
               pop_burst($urandom_range(1, 10));
            end else if (pick < 85) begin
               send_item(kwm_pkg::KIND_CLEAR, 3'($urandom), $urandom);
            end else if (pick < 95) begin
               send_item(2'($urandom_range(0, 3)), 3'($urandom), $urandom);
            end else begin
               repeat ($urandom_range(1, 6))
                  send_item(kwm_pkg::KIND_APPEND, 3'($urandom), $urandom);
            end
         end
      end

      // Drop valid, let every response arrive, then give the block time to
      // show any stray response before the verdict.
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: k_way_sorted_merge_core.f
rtl/core/kwm_pkg.sv
rtl/core/kwm_ctrl.sv
rtl/core/kwm_dpath.sv
rtl/core/k_way_sorted_merge_core.sv
rtl/core/kwm_checker.sv
tb/kwm_merge_checker.sv
tb/tb_top.sv
